### hw/rtl/kdpc_pkg.sv
// Shared constants and types for the key debounce and press classifier.
package kdpc_pkg;

    localparam int NUM_KEYS = 5;
    localparam int DEB_W    = 8;
    localparam int HOLD_W   = 16;
    localparam int CFG_W    = 16;

    localparam logic [HOLD_W-1:0] HOLD_MAX    = 16'hFFFF;
    localparam logic [DEB_W-1:0]  DEB_RESET   = 8'd3;
    localparam logic [HOLD_W-1:0] LONG_RESET  = 16'd100;

    typedef enum logic [1:0] {
        OP_SCAN  = 2'd0,
        OP_FETCH = 2'd1,
        OP_INIT  = 2'd2
    } op_t;

    localparam logic CFG_DEBOUNCE   = 1'b0;
    localparam logic CFG_LONG_PRESS = 1'b1;

    typedef struct packed {
        logic [DEB_W-1:0]  debounce_ticks;
        logic [HOLD_W-1:0] long_press_ticks;
    } cfg_t;

    typedef struct packed {
        logic scan;
        logic init;
    } lane_ctrl_t;

    typedef struct packed {
        logic short_evt;
        logic long_evt;
    } lane_evt_t;

endpackage

### hw/rtl/key_debounce_press_classifier_core.sv
// Top level: configuration registers, key lanes and event merge.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | s_op, s_key_levels
//  m_      | out       | m_valid / m_ready  | m_has_events, m_short_mask, m_long_mask
//  cfg_    | in        | cfg_we             | cfg_index, cfg_wdata
//
// One transaction per cycle while s_ready is high; all key lanes update in the cycle a scan is taken.
// A fetch result is registered on m_, or held in the skid stage while m_ is stalled.
// A skid stage behind the output register lets one more fetch through while
// a result is stalled; s_ready drops only when both are full.
// Reset is synchronous, active low, and clears all key and event state.
module key_debounce_press_classifier_core
    import kdpc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [CFG_W-1:0]    cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_op,
    input  logic [NUM_KEYS-1:0] s_key_levels,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_has_events,
    output logic [NUM_KEYS-1:0] m_short_mask,
    output logic [NUM_KEYS-1:0] m_long_mask
);

    cfg_t       cfg_reg, cfg_next;
    lane_ctrl_t ctrl;
    lane_evt_t  evt [NUM_KEYS];
    logic       s_fire;
    logic       fetch;
    logic       skid_full;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                CFG_DEBOUNCE:   cfg_next.debounce_ticks   = cfg_wdata[DEB_W-1:0];
                CFG_LONG_PRESS: cfg_next.long_press_ticks = cfg_wdata[HOLD_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ticks   <= DEB_RESET;
            cfg_reg.long_press_ticks <= LONG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign s_ready   = !skid_full;
    assign s_fire    = s_valid && s_ready;
    assign fetch     = s_fire && (s_op == OP_FETCH);
    assign ctrl.scan = s_fire && (s_op == OP_SCAN);
    assign ctrl.init = s_fire && (s_op == OP_INIT);

    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
        kdpc_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (ctrl),
            .raw     (s_key_levels[k]),
            .cfg     (cfg_reg),
            .evt     (evt[k])
        );
    end

    kdpc_merge u_merge (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fetch        (fetch),
        .init         (ctrl.init),
        .evt          (evt),
        .skid_full    (skid_full),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_has_events (m_has_events),
        .m_short_mask (m_short_mask),
        .m_long_mask  (m_long_mask)
    );

endmodule

### hw/rtl/kdpc_lane.sv
// Per-key debounce filter and short/long press detector.
module kdpc_lane
    import kdpc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  lane_ctrl_t ctrl,
    input  logic       raw,
    input  cfg_t       cfg,
    output lane_evt_t  evt
);

    logic              stable_reg, stable_next;
    logic              filter_reg, filter_next;
    logic [DEB_W-1:0]  deb_cnt_reg, deb_cnt_next;
    logic [HOLD_W-1:0] hold_reg, hold_next;
    logic              armed_reg, armed_next;
    logic              long_rep_reg, long_rep_next;

    always_comb begin
        stable_next   = stable_reg;
        filter_next   = filter_reg;
        deb_cnt_next  = deb_cnt_reg;
        hold_next     = hold_reg;
        armed_next    = armed_reg;
        long_rep_next = long_rep_reg;
        evt           = '0;
        if (ctrl.init) begin
            stable_next   = raw;
            filter_next   = raw;
            deb_cnt_next  = '0;
            hold_next     = '0;
            long_rep_next = 1'b0;
            armed_next    = raw;
        end else if (ctrl.scan) begin
            if (raw != filter_reg) begin
                filter_next  = raw;
                deb_cnt_next = '0;
            end else if (deb_cnt_reg < cfg.debounce_ticks) begin
                deb_cnt_next = deb_cnt_reg + 1'b1;
            end
            if (deb_cnt_next >= cfg.debounce_ticks) begin
                if (stable_reg != filter_next) begin
                    stable_next   = filter_next;
                    hold_next     = '0;
                    long_rep_next = 1'b0;
                    if (!filter_next) begin
                        if (armed_reg) begin
                            evt.short_evt = 1'b1;
                            armed_next    = 1'b0;
                        end
                    end else begin
                        armed_next = 1'b1;
                    end
                end else if (!stable_reg) begin
                    if (hold_reg < HOLD_MAX) begin
                        hold_next = hold_reg + 1'b1;
                    end
                    if (hold_next >= cfg.long_press_ticks && !long_rep_reg) begin
                        evt.long_evt  = 1'b1;
                        long_rep_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stable_reg   <= 1'b1;
            filter_reg   <= 1'b1;
            deb_cnt_reg  <= '0;
            hold_reg     <= '0;
            armed_reg    <= 1'b1;
            long_rep_reg <= 1'b0;
        end else begin
            stable_reg   <= stable_next;
            filter_reg   <= filter_next;
            deb_cnt_reg  <= deb_cnt_next;
            hold_reg     <= hold_next;
            armed_reg    <= armed_next;
            long_rep_reg <= long_rep_next;
        end
    end

endmodule

### hw/rtl/kdpc_merge.sv
// Pending event masks, fetch handling and the output register with skid stage.
module kdpc_merge
    import kdpc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fetch,
    input  logic                init,
    input  lane_evt_t           evt [NUM_KEYS],
    output logic                skid_full,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_has_events,
    output logic [NUM_KEYS-1:0] m_short_mask,
    output logic [NUM_KEYS-1:0] m_long_mask
);

    logic [NUM_KEYS-1:0] pend_short_reg, pend_short_next;
    logic [NUM_KEYS-1:0] pend_long_reg, pend_long_next;
    logic [NUM_KEYS-1:0] evt_short, evt_long;

    logic                out_valid_reg, out_valid_next;
    logic                out_has_reg, out_has_next;
    logic [NUM_KEYS-1:0] out_short_reg, out_short_next;
    logic [NUM_KEYS-1:0] out_long_reg, out_long_next;
    logic                skid_valid_reg, skid_valid_next;
    logic                skid_has_reg, skid_has_next;
    logic [NUM_KEYS-1:0] skid_short_reg, skid_short_next;
    logic [NUM_KEYS-1:0] skid_long_reg, skid_long_next;
    logic                res_has;

    always_comb begin
        for (int k = 0; k < NUM_KEYS; k++) begin
            evt_short[k] = evt[k].short_evt;
            evt_long[k]  = evt[k].long_evt;
        end
    end

    assign res_has = (pend_short_reg != '0) || (pend_long_reg != '0);

    always_comb begin
        if (init || fetch) begin
            pend_short_next = '0;
            pend_long_next  = '0;
        end else begin
            pend_short_next = pend_short_reg | evt_short;
            pend_long_next  = pend_long_reg | evt_long;
        end
    end

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_has_next    = out_has_reg;
        out_short_next  = out_short_reg;
        out_long_next   = out_long_reg;
        skid_valid_next = skid_valid_reg;
        skid_has_next   = skid_has_reg;
        skid_short_next = skid_short_reg;
        skid_long_next  = skid_long_reg;
        if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_has_next    = skid_has_reg;
                out_short_next  = skid_short_reg;
                out_long_next   = skid_long_reg;
                skid_valid_next = 1'b0;
            end else if (fetch) begin
                out_valid_next = 1'b1;
                out_has_next   = res_has;
                out_short_next = pend_short_reg;
                out_long_next  = pend_long_reg;
            end else begin
                out_valid_next = 1'b0;
            end
        end else if (fetch) begin
            skid_valid_next = 1'b1;
            skid_has_next   = res_has;
            skid_short_next = pend_short_reg;
            skid_long_next  = pend_long_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_short_reg <= '0;
            pend_long_reg  <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            pend_short_reg <= pend_short_next;
            pend_long_reg  <= pend_long_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_has_reg    <= out_has_next;
        out_short_reg  <= out_short_next;
        out_long_reg   <= out_long_next;
        skid_has_reg   <= skid_has_next;
        skid_short_reg <= skid_short_next;
        skid_long_reg  <= skid_long_next;
    end

    assign skid_full    = skid_valid_reg;
    assign m_valid      = out_valid_reg;
    assign m_has_events = out_has_reg;
    assign m_short_mask = out_short_reg;
    assign m_long_mask  = out_long_reg;

endmodule

### hw/rtl/kdpc_checker.sv
// Port-level checks for the key debounce core and their bind.
module kdpc_checker
    import kdpc_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic [1:0]          s_op,
    input logic                m_valid,
    input logic                m_ready,
    input logic                m_has_events,
    input logic [NUM_KEYS-1:0] m_short_mask,
    input logic [NUM_KEYS-1:0] m_long_mask
);

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result dropped before transaction");

    a_fetch_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_op == OP_FETCH && !m_valid) |=> m_valid)
        else $error("fetch gave no result");

    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_op != OP_FETCH && (!m_valid || m_ready)) |=> !m_valid)
        else $error("result without fetch");

    a_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_has_events == ((m_short_mask != '0) || (m_long_mask != '0))))
        else $error("event flag disagrees with masks");

endmodule

bind key_debounce_press_classifier_core kdpc_checker u_kdpc_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_op         (s_op),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_has_events (m_has_events),
    .m_short_mask (m_short_mask),
    .m_long_mask  (m_long_mask)
);

### sim/key_debounce_press_classifier_core_tb.sv
// Self-checking testbench for the key debounce and press classifier core.
`timescale 1ns / 1ps

module key_debounce_press_classifier_core_tb;
    import kdpc_pkg::*;

    localparam logic [1:0] OP_UNUSED       = 2'd3;
    localparam int         GAP_MAX         = 14;
    localparam int         STALL_LIMIT     = 2000;
    localparam int         DRAIN_LIMIT     = 1000;
    localparam int         DRAIN_CYCLES    = 4;
    localparam int         HOLD_OFF_CYCLES = 80;
    localparam int         PRINT_CAP       = 100;
    localparam int         PHASE_ITEMS     = 200;

    typedef struct packed {
        logic                has_events;
        logic [NUM_KEYS-1:0] short_mask;
        logic [NUM_KEYS-1:0] long_mask;
    } press_report_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_we = 1'b0;
    logic                cfg_index = CFG_DEBOUNCE;
    logic [CFG_W-1:0]    cfg_wdata = '0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [1:0]          s_op = OP_SCAN;
    logic [NUM_KEYS-1:0] s_key_levels = '1;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic                m_has_events;
    logic [NUM_KEYS-1:0] m_short_mask;
    logic [NUM_KEYS-1:0] m_long_mask;

    logic                sink_hold_req = 1'b0;
    int                  sink_wait;
    int                  src_gap_max = GAP_MAX;
    int                  sink_gap_max = GAP_MAX;
    int                  error_count = 0;

    logic [DEB_W-1:0]    debounce_setting;
    logic [HOLD_W-1:0]   long_setting;
    logic [NUM_KEYS-1:0] key_stable;
    logic [NUM_KEYS-1:0] key_filter;
    logic [NUM_KEYS-1:0] key_armed;
    logic [NUM_KEYS-1:0] key_long_seen;
    logic [DEB_W-1:0]    key_settle [NUM_KEYS];
    logic [HOLD_W-1:0]   key_held [NUM_KEYS];
    logic [NUM_KEYS-1:0] short_latched;
    logic [NUM_KEYS-1:0] long_latched;
    press_report_t       report_q [$];

    key_debounce_press_classifier_core DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_key_levels (s_key_levels),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_has_events (m_has_events),
        .m_short_mask (m_short_mask),
        .m_long_mask  (m_long_mask)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        if (error_count < PRINT_CAP) begin
            $display("mismatch at %0t: %s", $time, what);
        end
        error_count++;
    endtask

    function automatic void clear_key_state();
        for (int k = 0; k < NUM_KEYS; k++) begin
            key_settle[k] = '0;
            key_held[k]   = '0;
        end
        key_long_seen = '0;
        short_latched = '0;
        long_latched  = '0;
    endfunction

    function automatic void scan_key(input int k, input logic raw);
        if (raw != key_filter[k]) begin
            key_filter[k] = raw;
            key_settle[k] = '0;
        end else if (key_settle[k] < debounce_setting) begin
            key_settle[k]++;
        end
        if (key_settle[k] < debounce_setting) begin
            return;
        end
        if (key_stable[k] != key_filter[k]) begin
            key_stable[k]    = key_filter[k];
            key_held[k]      = '0;
            key_long_seen[k] = 1'b0;
            if (!key_stable[k]) begin
                if (key_armed[k]) begin
                    short_latched[k] = 1'b1;
                    key_armed[k]     = 1'b0;
                end
            end else begin
                key_armed[k] = 1'b1;
            end
        end else if (!key_stable[k]) begin
            if (key_held[k] != HOLD_MAX) begin
                key_held[k]++;
            end
            if (key_held[k] >= long_setting && !key_long_seen[k]) begin
                long_latched[k]  = 1'b1;
                key_long_seen[k] = 1'b1;
            end
        end
    endfunction

    function automatic void track_item(input logic [1:0] op, input logic [NUM_KEYS-1:0] levels);
        press_report_t fetched;
        case (op)
            OP_SCAN: begin
                for (int k = 0; k < NUM_KEYS; k++) begin
                    scan_key(k, levels[k]);
                end
            end
            OP_FETCH: begin
                fetched.has_events = (short_latched != '0) || (long_latched != '0);
                fetched.short_mask = short_latched;
                fetched.long_mask  = long_latched;
                report_q.push_back(fetched);
                short_latched = '0;
                long_latched  = '0;
            end
            OP_INIT: begin
                clear_key_state();
                key_stable = levels;
                key_filter = levels;
                key_armed  = levels;
            end
            default: begin
            end
        endcase
    endfunction

    always @(posedge aclk) begin : track_and_check
        press_report_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (report_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result has=%b short=%b long=%b",
                                              m_has_events, m_short_mask, m_long_mask));
                end else begin
                    want = report_q.pop_front();
                    if (m_has_events !== want.has_events)
                        report_mismatch($sformatf("has_events %b, want %b",
                                                  m_has_events, want.has_events));
                    if (m_short_mask !== want.short_mask)
                        report_mismatch($sformatf("short_mask %b, want %b",
                                                  m_short_mask, want.short_mask));
                    if (m_long_mask !== want.long_mask)
                        report_mismatch($sformatf("long_mask %b, want %b",
                                                  m_long_mask, want.long_mask));
                end
            end
            if (s_valid && s_ready) begin
                track_item(s_op, s_key_levels);
            end
        end
    end

    always @(posedge aclk) begin : sink_pacing
        int next_wait;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            sink_wait <= 0;
        end else if (sink_hold_req) begin
            m_ready <= 1'b0;
        end else if (!m_ready) begin
            if (sink_wait == 0) m_ready <= 1'b1;
            else sink_wait <= sink_wait - 1;
        end else if (m_valid) begin
            next_wait = $urandom_range(0, sink_gap_max);
            sink_wait <= next_wait;
            m_ready   <= (next_wait == 0);
        end
    end

    initial begin : watchdog
        int stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) stalled = 0;
            else stalled++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    task automatic send_item(input logic [1:0] op, input logic [NUM_KEYS-1:0] levels);
        int gap;
        s_op         <= op;
        s_key_levels <= levels;
        s_valid      <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        gap = $urandom_range(0, src_gap_max);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic settle_block();
        int waited;
        s_valid <= 1'b0;
        @(posedge aclk);
        waited = 0;
        while (report_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (report_q.size() != 0) begin
            report_mismatch($sformatf("%0d fetch results never arrived", report_q.size()));
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Write both registers; junk above the debounce field must be dropped.
    task automatic apply_settings(input logic [DEB_W-1:0] deb, input logic [HOLD_W-1:0] lng);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DEBOUNCE;
        cfg_wdata <= {(CFG_W-DEB_W)'($urandom), deb};
        @(posedge aclk);
        cfg_index <= CFG_LONG_PRESS;
        cfg_wdata <= lng;
        @(posedge aclk);
        cfg_we <= 1'b0;
        debounce_setting = deb;
        long_setting     = lng;
    endtask

    task automatic test_directed();
        send_item(OP_FETCH, 5'h1F);
        send_item(OP_UNUSED, 5'h00);
        send_item(OP_SCAN, 5'h1F);
        repeat (4) send_item(OP_SCAN, 5'h00);
        send_item(OP_FETCH, 5'h00);
        send_item(OP_FETCH, 5'h00);
        send_item(OP_INIT, 5'h0A);
        repeat (3) send_item(OP_SCAN, 5'h0A);
        send_item(OP_FETCH, 5'h0A);
        repeat (4) send_item(OP_SCAN, 5'h1F);
        repeat (4) send_item(OP_SCAN, 5'h15);
        send_item(OP_FETCH, 5'h1F);
    endtask

    task automatic test_setting_extremes();
        settle_block();
        apply_settings(8'd0, 16'd0);
        send_item(OP_INIT, 5'h1F);
        repeat (2) send_item(OP_SCAN, 5'h1E);
        send_item(OP_FETCH, 5'h00);
        send_item(OP_SCAN, 5'h1F);
        repeat (2) send_item(OP_SCAN, 5'h00);
        send_item(OP_FETCH, 5'h00);

        // lower the debounce count below a count already reached
        settle_block();
        apply_settings(8'd200, 16'hFFFF);
        send_item(OP_INIT, 5'h1F);
        repeat (50) send_item(OP_SCAN, 5'h00);
        settle_block();
        apply_settings(8'd5, 16'd3);
        repeat (4) send_item(OP_SCAN, 5'h00);
        send_item(OP_FETCH, 5'h00);

        src_gap_max  = 0;
        sink_gap_max = 0;
        settle_block();
        apply_settings(8'd255, 16'd1);
        send_item(OP_INIT, 5'h1F);
        repeat (258) send_item(OP_SCAN, 5'h15);
        send_item(OP_FETCH, 5'h15);
        settle_block();
        src_gap_max  = GAP_MAX;
        sink_gap_max = GAP_MAX;
    endtask

    task automatic test_output_stall();
        settle_block();
        apply_settings(8'd1, 16'd2);
        fork
            begin
                sink_hold_req <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                sink_hold_req <= 1'b0;
            end
            begin
                src_gap_max = 0;
                for (int i = 0; i < 24; i++) begin
                    if (i % 3 == 0) send_item(OP_SCAN, NUM_KEYS'($urandom));
                    else send_item(OP_FETCH, NUM_KEYS'($urandom));
                end
                src_gap_max = GAP_MAX;
            end
        join
        settle_block();
    endtask

    task automatic test_random_traffic();
        logic [NUM_KEYS-1:0] held_levels;
        int                  deb;
        int                  lng;
        int                  run_left;
        int                  roll;
        for (int phase = 0; phase < 8; phase++) begin
            settle_block();
            case (phase)
                0: begin deb = 0;   lng = 0;     end
                1: begin deb = 1;   lng = 1;     end
                2: begin deb = 255; lng = 1;     end
                3: begin deb = 2;   lng = 65535; end
                default: begin
                    deb = $urandom_range(0, 6);
                    lng = $urandom_range(0, 40);
                end
            endcase
            apply_settings(DEB_W'(deb), HOLD_W'(lng));
            src_gap_max  = (phase == 5) ? 0 : GAP_MAX;
            sink_gap_max = (phase == 5) ? 0 : GAP_MAX;
            held_levels  = NUM_KEYS'($urandom);
            run_left     = 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < 12) begin
                    send_item(OP_FETCH, NUM_KEYS'($urandom));
                end else if (roll < 13) begin
                    held_levels = NUM_KEYS'($urandom);
                    send_item(OP_INIT, held_levels);
                end else if (roll < 14) begin
                    send_item(OP_UNUSED, NUM_KEYS'($urandom));
                end else if (roll < 19) begin
                    send_item(OP_SCAN, held_levels ^ (NUM_KEYS'(1) << $urandom_range(0, 4)));
                end else if (roll < 21) begin
                    send_item(OP_SCAN, NUM_KEYS'($urandom));
                end else begin
                    if (run_left == 0) begin
                        held_levels ^= NUM_KEYS'($urandom_range(1, (1 << NUM_KEYS) - 1));
                        run_left = $urandom_range(1, 2 * deb + (lng > 40 ? 40 : lng) + 6);
                    end
                    run_left--;
                    send_item(OP_SCAN, held_levels);
                end
                if (phase == 6 && n == PHASE_ITEMS / 2) begin
                    settle_block();
                end
            end
        end
        src_gap_max  = GAP_MAX;
        sink_gap_max = GAP_MAX;
    endtask

    initial begin
        debounce_setting = DEB_RESET;
        long_setting     = LONG_RESET;
        clear_key_state();
        key_stable = '1;
        key_filter = '1;
        key_armed  = '1;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_setting_extremes();
        test_output_stall();
        test_random_traffic();
        settle_block();
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/kdpc_pkg.sv
hw/rtl/kdpc_lane.sv
hw/rtl/kdpc_merge.sv
hw/rtl/key_debounce_press_classifier_core.sv
hw/rtl/kdpc_checker.sv
sim/key_debounce_press_classifier_core_tb.sv
